[sv/tzv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tzv_pkg: shared types, constants and the per-pass parse function
// Phase codes, character codes, field limits and the parser state record
// used by the time zone string validator.
// ----------------------------------------------------------------------------
package tzv_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int LEN_OUT_BITS    = 16;
  // longest hand-off chain for one byte is three dispatches: a name ended by
  // a digit moves to the sign phase, which hands the digit to the time phase
  localparam int MAX_PASSES      = 3;

  // parse phases; rule phases are a rule base plus a rule offset
  localparam logic [4:0] PH_STD_NAME = 5'd0;
  localparam logic [4:0] PH_STD_SIGN = 5'd1;
  localparam logic [4:0] PH_STD_TIME = 5'd2;
  localparam logic [4:0] PH_DST_NAME = 5'd3;
  localparam logic [4:0] PH_DST_SIGN = 5'd4;
  localparam logic [4:0] PH_DST_TIME = 5'd5;
  localparam logic [4:0] PH_DST_DONE = 5'd6;
  localparam logic [4:0] PH_R1       = 5'd7;
  localparam logic [4:0] PH_R2       = 5'd14;

  localparam logic [4:0] RO_BEGIN = 5'd0;
  localparam logic [4:0] RO_JDAY  = 5'd1;
  localparam logic [4:0] RO_NDAY  = 5'd2;
  localparam logic [4:0] RO_MDATE = 5'd3;
  localparam logic [4:0] RO_SLASH = 5'd4;
  localparam logic [4:0] RO_TIME  = 5'd5;
  localparam logic [4:0] RO_DONE  = 5'd6;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_M     = 8'h4D;

  // field limits
  localparam logic [9:0] LIM_HOUR  = 10'd23;
  localparam logic [9:0] LIM_MIN   = 10'd59;
  localparam logic [9:0] LIM_DAY   = 10'd365;
  localparam logic [9:0] LIM_MONTH = 10'd12;
  localparam logic [9:0] LIM_WEEK  = 10'd5;
  localparam logic [1:0] MAX_DIGITS = 2'd3;
  localparam logic [1:0] MIN_NAME   = 2'd3;
  localparam logic [1:0] LAST_SUB   = 2'd2;

  typedef struct packed {
    logic [4:0] phase;
    logic [1:0] name_cnt;
    logic [1:0] digit_cnt;
    logic [9:0] num;
    logic [1:0] sub;
    logic       err;
  } parse_st_t;

  typedef struct packed {
    parse_st_t st;
    logic      taken;
    logic      ok;
  } step_res_t;

  localparam parse_st_t PARSE_RESET = '{phase: PH_STD_NAME, name_cnt: 2'd0,
                                        digit_cnt: 2'd0, num: 10'd0,
                                        sub: 2'd0, err: 1'b0};

  // move to a new phase with cleared counters; error flag is kept
  function automatic parse_st_t enter(parse_st_t s, logic [4:0] ph);
    parse_st_t t;
    t       = PARSE_RESET;
    t.phase = ph;
    t.err   = s.err;
    return t;
  endfunction

  // one dispatch of the current byte; taken low means the byte is offered again
  function automatic step_res_t parse_step(parse_st_t s, logic [7:0] c);
    step_res_t  r;
    logic       dig;
    logic       stop;
    logic       num_end;
    logic       second;
    logic       in_r1;
    logic       in_r2;
    logic [4:0] base;
    logic [4:0] off;
    logic [9:0] lim;
    logic [9:0] digit_val;
    parse_st_t  ds;
    r.st      = s;
    r.taken   = 1'b1;
    r.ok      = 1'b0;
    dig       = (c >= CH_ZERO) && (c <= CH_NINE);
    stop      = dig || c == CH_COMMA || c == CH_PLUS || c == CH_MINUS || c == CH_NUL;
    digit_val = 10'(c - CH_ZERO);

    // digit accumulation shared by every number field
    ds      = s;
    num_end = 1'b0;
    if (dig) begin
      if (s.digit_cnt >= MAX_DIGITS) begin
        ds.err = 1'b1;
      end else begin
        ds.digit_cnt = s.digit_cnt + 2'd1;
        ds.num       = (s.num << 3) + (s.num << 1) + digit_val;
      end
    end else if (s.digit_cnt == 2'd0) begin
      ds.err = 1'b1;
    end else begin
      num_end = 1'b1;
    end

    in_r1  = (s.phase >= PH_R1) && (s.phase < PH_R2);
    in_r2  = (s.phase >= PH_R2) && (s.phase <= PH_R2 + RO_DONE);
    second = in_r2;
    base   = in_r2 ? PH_R2 : PH_R1;
    off    = s.phase - base;

    case (s.phase)
      PH_STD_NAME, PH_DST_NAME: begin
        if (s.name_cnt == 2'd0 && c == CH_COLON) begin
          r.st.err = 1'b1;
        end else if (!stop) begin
          if (s.name_cnt < MIN_NAME) r.st.name_cnt = s.name_cnt + 2'd1;
        end else if (s.name_cnt < MIN_NAME) begin
          r.st.err = 1'b1;
        end else if (c == CH_NUL) begin
          r.ok = 1'b1;
        end else if (s.phase == PH_STD_NAME) begin
          r.st    = enter(s, PH_STD_SIGN);
          r.taken = 1'b0;
        end else if (c == CH_COMMA) begin
          r.st = enter(s, PH_R1 + RO_BEGIN);
        end else begin
          r.st    = enter(s, PH_DST_SIGN);
          r.taken = 1'b0;
        end
      end
      PH_STD_SIGN, PH_DST_SIGN: begin
        r.st    = enter(s, s.phase + 5'd1);
        r.taken = (c == CH_PLUS) || (c == CH_MINUS);
      end
      PH_STD_TIME, PH_DST_TIME: begin
        if (!num_end) begin
          r.st = ds;
        end else if (s.num > ((s.sub == 2'd0) ? LIM_HOUR : LIM_MIN)) begin
          r.st.err = 1'b1;
        end else if (c == CH_COLON && s.sub < LAST_SUB) begin
          r.st.sub       = s.sub + 2'd1;
          r.st.digit_cnt = 2'd0;
          r.st.num       = 10'd0;
        end else if (s.phase == PH_STD_TIME && c == CH_NUL) begin
          r.ok = 1'b1;
        end else begin
          r.st    = enter(s, (s.phase == PH_STD_TIME) ? PH_DST_NAME : PH_DST_DONE);
          r.taken = 1'b0;
        end
      end
      PH_DST_DONE: begin
        if (c == CH_COMMA) r.st = enter(s, PH_R1 + RO_BEGIN);
        else if (c == CH_NUL) r.ok = 1'b1;
        else r.st.err = 1'b1;
      end
      default: begin
        if (!in_r1 && !in_r2) begin
          r.st.err = 1'b1;
        end else begin
          case (off)
            RO_BEGIN: begin
              if (!second && c == CH_COMMA) begin
                r.st = enter(s, PH_R2 + RO_BEGIN);
              end else if (c == CH_J) begin
                r.st = enter(s, base + RO_JDAY);
              end else if (c == CH_M) begin
                r.st = enter(s, base + RO_MDATE);
              end else begin
                r.st    = enter(s, base + RO_NDAY);
                r.taken = 1'b0;
              end
            end
            RO_JDAY, RO_NDAY: begin
              if (!num_end) begin
                r.st = ds;
              end else if (s.num > LIM_DAY || (off == RO_JDAY && s.num == 10'd0)) begin
                r.st.err = 1'b1;
              end else begin
                r.st    = enter(s, base + RO_SLASH);
                r.taken = 1'b0;
              end
            end
            RO_MDATE: begin
              lim = (s.sub == 2'd0) ? LIM_MONTH : LIM_WEEK;
              if (!num_end) begin
                r.st = ds;
              end else if (s.num == 10'd0 || s.num > lim) begin
                r.st.err = 1'b1;
              end else if (s.sub < LAST_SUB) begin
                if (c != CH_DOT) begin
                  r.st.err = 1'b1;
                end else begin
                  r.st.sub       = s.sub + 2'd1;
                  r.st.digit_cnt = 2'd0;
                  r.st.num       = 10'd0;
                end
              end else begin
                r.st    = enter(s, base + RO_SLASH);
                r.taken = 1'b0;
              end
            end
            RO_SLASH: begin
              if (c == CH_SLASH) begin
                r.st = enter(s, base + RO_TIME);
              end else begin
                r.st    = enter(s, base + RO_DONE);
                r.taken = 1'b0;
              end
            end
            RO_TIME: begin
              if (!num_end) begin
                r.st = ds;
              end else if (s.num > ((s.sub == 2'd0) ? LIM_HOUR : LIM_MIN)) begin
                r.st.err = 1'b1;
              end else if (c == CH_COLON && s.sub < LAST_SUB) begin
                r.st.sub       = s.sub + 2'd1;
                r.st.digit_cnt = 2'd0;
                r.st.num       = 10'd0;
              end else begin
                r.st    = enter(s, base + RO_DONE);
                r.taken = 1'b0;
              end
            end
            default: begin
              if (!second && c == CH_COMMA) r.st = enter(s, PH_R2 + RO_BEGIN);
              else if (second && c == CH_NUL) r.ok = 1'b1;
              else r.st.err = 1'b1;
            end
          endcase
        end
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/tzv_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tzv_parser: one-byte parse update
// Offers the byte to the phase logic until a phase consumes it, an error is
// flagged, or the pass limit is reached; returns next state and the ok flag.
// ----------------------------------------------------------------------------
module tzv_parser (
  input  wire tzv_pkg::parse_st_t cur_st,
  input  wire logic [7:0]         ch,
  output tzv_pkg::parse_st_t      nxt_st,
  output logic                    ok
);

  tzv_pkg::step_res_t pass_res [tzv_pkg::MAX_PASSES];
  tzv_pkg::parse_st_t pass_st  [tzv_pkg::MAX_PASSES+1];
  logic               pass_done[tzv_pkg::MAX_PASSES+1];
  logic               pass_ok  [tzv_pkg::MAX_PASSES+1];

  // chain the passes; a finished byte leaves later passes untouched
  always_comb begin
    pass_st[0]   = cur_st;
    pass_done[0] = 1'b0;
    pass_ok[0]   = 1'b0;
    for (int i = 0; i < tzv_pkg::MAX_PASSES; i++) begin
      pass_res[i]    = tzv_pkg::parse_step(pass_st[i], ch);
      pass_st[i+1]   = pass_st[i];
      pass_done[i+1] = pass_done[i];
      pass_ok[i+1]   = pass_ok[i];
      if (!pass_done[i]) begin
        if (pass_st[i].err) begin
          pass_done[i+1] = 1'b1;
          pass_ok[i+1]   = 1'b0;
        end else begin
          pass_st[i+1] = pass_res[i].st;
          if (pass_res[i].taken) begin
            pass_done[i+1] = 1'b1;
            pass_ok[i+1]   = pass_res[i].ok;
          end
        end
      end
    end
    nxt_st = pass_st[tzv_pkg::MAX_PASSES];
    ok     = pass_ok[tzv_pkg::MAX_PASSES] && !pass_st[tzv_pkg::MAX_PASSES].err;
  end

endmodule
`default_nettype wire

[sv/tz_string_validator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tz_string_validator: POSIX time zone string checker
// Streams a zone string byte by byte and reports validity and length.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back. A byte is captured in an input
// register and parsed in the following cycle by a short chain of phase
// dispatches (at most three per byte); a zero byte then loads the result
// register, from which the result is offered after its terminating byte is
// accepted. The rate is one byte per cycle; the input stalls only while a
// held zero byte waits for a previous result that has not yet been taken,
// and that stall follows out_stall in the same cycle. The byte counter
// saturates at 2^LENGTH_BITS-1 and the reported length at 65535; an invalid
// string reports length zero. The parser returns to its start state after
// every zero byte.
module tz_string_validator #(
  parameter int LENGTH_BITS = tzv_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_valid_res,
  output logic [15:0]      out_length
);

  logic                     in_v_r, in_v_nxt;
  logic [7:0]               ch_r;
  logic                     adv;
  logic                     accept;
  logic                     is_end;
  tzv_pkg::parse_st_t       st_r, st_nxt, parse_nxt;
  logic                     parse_ok;
  logic [LENGTH_BITS-1:0]   cnt_r, cnt_nxt;
  logic [15:0]              len_sat;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_res_r;
  logic [15:0]              out_len_r;

  tzv_parser u_parser (
    .cur_st (st_r),
    .ch     (ch_r),
    .nxt_st (parse_nxt),
    .ok     (parse_ok)
  );

  // advance the held byte unless a terminator finds the result slot busy
  assign is_end   = (ch_r == tzv_pkg::CH_NUL);
  assign adv      = in_v_r && (!is_end || !out_valid_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign in_v_nxt = accept ? 1'b1 : (adv ? 1'b0 : in_v_r);

  // clamp the byte count to the output field
  generate
    if (LENGTH_BITS > 16) begin : g_len_wide
      assign len_sat = (|cnt_r[LENGTH_BITS-1:16]) ? 16'hFFFF : cnt_r[15:0];
    end else begin : g_len_narrow
      assign len_sat = 16'(cnt_r);
    end
  endgenerate

  // parser state and byte counter; restart after the terminator
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    if (adv) begin
      if (is_end) begin
        st_nxt  = tzv_pkg::PARSE_RESET;
        cnt_nxt = '0;
      end else begin
        st_nxt = parse_nxt;
        if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // result slot: load on terminator, drop when taken
  assign out_valid_nxt = (adv && is_end) ? 1'b1 :
                         ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      st_r        <= tzv_pkg::PARSE_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_v_r      <= in_v_nxt;
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) ch_r <= in_ch;
    if (adv && is_end) begin
      out_res_r <= parse_ok;
      out_len_r <= parse_ok ? len_sat : 16'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;
  assign out_length    = out_len_r;

endmodule
`default_nettype wire

[test/tb_tz_string_validator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tz_string_validator: self-checking bench for the zone string validator
// Streams directed and random zone strings into the block, predicts the
// verdict and length of every string in a behavioral parser, and compares
// each result transaction against the oldest prediction under varied
// sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_tz_string_validator;

  import tzv_pkg::*;

  localparam int         CYCLE_LIMIT = 600000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         END_CYCLES  = 20;
  localparam int         PHASE_ITEMS = 130;
  localparam int         FEED_LIMIT  = 8;
  localparam logic [15:0] COUNT_SAT  = 16'hFFFF;

  typedef enum bit { STEP_AGAIN, STEP_USED } step_t;
  typedef enum logic [1:0] { NUM_MORE, NUM_DONE, NUM_ERR } num_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] length;
  } zone_verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_valid_res;
  logic [15:0] out_length;

  logic [7:0]    byte_backlog[$];
  zone_verdict_t expected_verdicts[$];
  logic          in_took = 1'b0;
  int            snd_idle_pct = 0;
  int            rcv_stall_pct = 0;
  bit            hold_req = 1'b0;
  int            hold_left = 0;
  int            fail_cnt = 0;
  int            cycle_cnt = 0;
  int            pushed = 0;

  // predictor state
  logic [4:0]  zp_phase;
  logic [1:0]  zp_name;
  logic [1:0]  zp_digits;
  logic [1:0]  zp_sub;
  logic [9:0]  zp_num;
  logic        zp_err;
  logic        zp_ok;
  logic [15:0] zp_count;

  tz_string_validator uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ch         (in_ch),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_length    (out_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Behavioral parser
  // ------------------------------------------------------------------

  function automatic void zp_enter(logic [4:0] ph);
    zp_phase  = ph;
    zp_name   = 2'd0;
    zp_sub    = 2'd0;
    zp_digits = 2'd0;
    zp_num    = 10'd0;
  endfunction

  function automatic void zp_reset();
    zp_enter(PH_STD_NAME);
    zp_err   = 1'b0;
    zp_count = 16'd0;
  endfunction

  function automatic step_t zp_fail();
    zp_err = 1'b1;
    return STEP_USED;
  endfunction

  // accumulate one digit, or report the end of a number
  function automatic num_t zp_digit(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (zp_digits >= MAX_DIGITS) begin
        zp_err = 1'b1;
        return NUM_ERR;
      end
      zp_digits = zp_digits + 2'd1;
      zp_num    = 10'(zp_num * 10 + (c - CH_ZERO));
      return NUM_MORE;
    end
    if (zp_digits == 2'd0) begin
      zp_err = 1'b1;
      return NUM_ERR;
    end
    return NUM_DONE;
  endfunction

  function automatic step_t zp_name_step(logic [7:0] c, bit dst);
    logic stop;
    stop = (c >= CH_ZERO && c <= CH_NINE) || c == CH_COMMA || c == CH_PLUS ||
           c == CH_MINUS || c == CH_NUL;
    if (zp_name == 2'd0 && c == CH_COLON) return zp_fail();
    if (!stop) begin
      if (zp_name < MIN_NAME) zp_name = zp_name + 2'd1;
      return STEP_USED;
    end
    if (zp_name < MIN_NAME) return zp_fail();
    if (c == CH_NUL) begin
      zp_ok = 1'b1;
      return STEP_USED;
    end
    if (!dst) begin
      zp_enter(PH_STD_SIGN);
      return STEP_AGAIN;
    end
    if (c == CH_COMMA) begin
      zp_enter(PH_R1 + RO_BEGIN);
      return STEP_USED;
    end
    zp_enter(PH_DST_SIGN);
    return STEP_AGAIN;
  endfunction

  function automatic step_t zp_time_step(logic [7:0] c, logic [4:0] nxt, bit may_end);
    if (zp_digit(c) != NUM_DONE) return STEP_USED;
    if (zp_num > ((zp_sub == 2'd0) ? LIM_HOUR : LIM_MIN)) return zp_fail();
    if (c == CH_COLON && zp_sub < LAST_SUB) begin
      zp_sub    = zp_sub + 2'd1;
      zp_digits = 2'd0;
      zp_num    = 10'd0;
      return STEP_USED;
    end
    if (may_end && c == CH_NUL) begin
      zp_ok = 1'b1;
      return STEP_USED;
    end
    zp_enter(nxt);
    return STEP_AGAIN;
  endfunction

  function automatic step_t zp_rule_step(logic [7:0] c, logic [4:0] base);
    logic [4:0] off;
    bit         second;
    off    = zp_phase - base;
    second = (base == PH_R2);
    case (off)
      RO_BEGIN: begin
        if (!second && c == CH_COMMA) begin
          zp_enter(PH_R2 + RO_BEGIN);
          return STEP_USED;
        end
        if (c == CH_J) begin
          zp_enter(base + RO_JDAY);
          return STEP_USED;
        end
        if (c == CH_M) begin
          zp_enter(base + RO_MDATE);
          return STEP_USED;
        end
        zp_enter(base + RO_NDAY);
        return STEP_AGAIN;
      end
      RO_JDAY, RO_NDAY: begin
        if (zp_digit(c) != NUM_DONE) return STEP_USED;
        if (zp_num > LIM_DAY || (off == RO_JDAY && zp_num == 10'd0)) return zp_fail();
        zp_enter(base + RO_SLASH);
        return STEP_AGAIN;
      end
      RO_MDATE: begin
        if (zp_digit(c) != NUM_DONE) return STEP_USED;
        if (zp_num == 10'd0 || zp_num > ((zp_sub == 2'd0) ? LIM_MONTH : LIM_WEEK))
          return zp_fail();
        if (zp_sub < LAST_SUB) begin
          if (c != CH_DOT) return zp_fail();
          zp_sub    = zp_sub + 2'd1;
          zp_digits = 2'd0;
          zp_num    = 10'd0;
          return STEP_USED;
        end
        zp_enter(base + RO_SLASH);
        return STEP_AGAIN;
      end
      RO_SLASH: begin
        if (c == CH_SLASH) begin
          zp_enter(base + RO_TIME);
          return STEP_USED;
        end
        zp_enter(base + RO_DONE);
        return STEP_AGAIN;
      end
      RO_TIME: return zp_time_step(c, base + RO_DONE, 1'b0);
      default: begin
        if (!second && c == CH_COMMA) begin
          zp_enter(PH_R2 + RO_BEGIN);
          return STEP_USED;
        end
        if (second && c == CH_NUL) begin
          zp_ok = 1'b1;
          return STEP_USED;
        end
        return zp_fail();
      end
    endcase
  endfunction

  function automatic step_t zp_dispatch(logic [7:0] c);
    case (zp_phase)
      PH_STD_NAME: return zp_name_step(c, 1'b0);
      PH_STD_SIGN: begin
        zp_enter(PH_STD_TIME);
        return (c == CH_PLUS || c == CH_MINUS) ? STEP_USED : STEP_AGAIN;
      end
      PH_STD_TIME: return zp_time_step(c, PH_DST_NAME, 1'b1);
      PH_DST_NAME: return zp_name_step(c, 1'b1);
      PH_DST_SIGN: begin
        zp_enter(PH_DST_TIME);
        return (c == CH_PLUS || c == CH_MINUS) ? STEP_USED : STEP_AGAIN;
      end
      PH_DST_TIME: return zp_time_step(c, PH_DST_DONE, 1'b0);
      PH_DST_DONE: begin
        if (c == CH_COMMA) begin
          zp_enter(PH_R1 + RO_BEGIN);
          return STEP_USED;
        end
        if (c == CH_NUL) begin
          zp_ok = 1'b1;
          return STEP_USED;
        end
        return zp_fail();
      end
      default: begin
        if (zp_phase >= PH_R1 && zp_phase < PH_R2) return zp_rule_step(c, PH_R1);
        if (zp_phase >= PH_R2 && zp_phase <= PH_R2 + RO_DONE) return zp_rule_step(c, PH_R2);
        return zp_fail();
      end
    endcase
  endfunction

  // offer one byte to the parser until some phase consumes it or an error is flagged
  function automatic void zp_feed(logic [7:0] c);
    zp_ok = 1'b0;
    for (int n = 0; n < FEED_LIMIT; n++) begin
      if (zp_err) break;
      if (zp_dispatch(c) == STEP_USED) break;
    end
  endfunction

  function automatic void predict_zone_byte(logic [7:0] c);
    zone_verdict_t v;
    if (c != CH_NUL) begin
      if (zp_count != COUNT_SAT) zp_count = zp_count + 16'd1;
      zp_feed(c);
    end else begin
      zp_feed(c);
      v.valid_res = zp_ok && !zp_err;
      v.length    = v.valid_res ? zp_count : 16'd0;
      expected_verdicts.push_back(v);
      zp_reset();
    end
  endfunction

  // ------------------------------------------------------------------
  // Stimulus builders
  // ------------------------------------------------------------------

  function automatic bit chance(int p);
    return $urandom_range(0, 99) < p;
  endfunction

  task automatic put_byte(logic [7:0] b);
    byte_backlog.push_back(b);
    pushed++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_zone_str(string s);
    put_text(s);
    put_byte(CH_NUL);
  endtask

  task automatic maybe_noise();
    if (chance(3)) put_byte(8'($urandom_range(1, 255)));
  endtask

  // decimal number with optional leading zeros, now and then one digit too many
  task automatic put_num(int v);
    string t;
    int    pad;
    t   = $sformatf("%0d", v);
    pad = (t.len() < 3) ? $urandom_range(0, 3 - t.len()) : 0;
    if (chance(3)) pad++;
    repeat (pad) put_byte(CH_ZERO);
    put_text(t);
  endtask

  task automatic put_name();
    int         len;
    int         r;
    logic [7:0] b;
    len = chance(90) ? $urandom_range(3, 7) : $urandom_range(0, 2);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (i == 0 && chance(5)) begin
        b = CH_COLON;
      end else if (r < 6) begin
        b = chance(50) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
      end else if (r < 8) begin
        b = 8'($urandom_range(128, 255));
      end else begin
        do b = 8'($urandom_range(1, 127));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COMMA || b == CH_PLUS ||
               b == CH_MINUS);
      end
      put_byte(b);
    end
  endtask

  task automatic put_time(bit with_sign);
    int s;
    if (with_sign) begin
      s = $urandom_range(0, 2);
      if (s == 1) put_byte(CH_PLUS);
      else if (s == 2) put_byte(CH_MINUS);
    end
    if (!chance(2)) put_num(chance(85) ? $urandom_range(0, 23) : $urandom_range(24, 99));
    if (chance(50)) begin
      put_byte(CH_COLON);
      put_num(chance(90) ? $urandom_range(0, 59) : $urandom_range(60, 99));
      if (chance(50)) begin
        put_byte(CH_COLON);
        put_num(chance(90) ? $urandom_range(0, 59) : $urandom_range(60, 99));
      end
    end
  endtask

  task automatic put_rule();
    case ($urandom_range(0, 2))
      0: begin
        put_byte(CH_J);
        put_num(chance(90) ? $urandom_range(1, 365) : (chance(50) ? 0 : 366));
      end
      1: put_num(chance(90) ? $urandom_range(0, 365) : $urandom_range(366, 999));
      default: begin
        put_byte(CH_M);
        put_num(chance(92) ? $urandom_range(1, 12) : (chance(50) ? 0 : 13));
        put_byte(chance(96) ? CH_DOT : 8'($urandom_range(1, 255)));
        put_num(chance(92) ? $urandom_range(1, 5) : (chance(50) ? 0 : 6));
        put_byte(chance(96) ? CH_DOT : 8'($urandom_range(1, 255)));
        put_num(chance(92) ? $urandom_range(1, 5) : (chance(50) ? 0 : 6));
      end
    endcase
    if (chance(40)) begin
      put_byte(CH_SLASH);
      put_time(1'b0);
    end
  endtask

  // one zone string: mostly well formed with random content, some raw noise
  task automatic put_zone();
    if (chance(12)) begin
      repeat ($urandom_range(0, 15)) put_byte(8'($urandom_range(1, 255)));
    end else begin
      put_name();
      maybe_noise();
      if (!chance(10)) begin
        put_time(1'b1);
        maybe_noise();
        if (!chance(15)) begin
          put_name();
          maybe_noise();
          if (!chance(15)) begin
            if (chance(50)) put_time(1'b1);
            if (!chance(15)) begin
              put_byte(CH_COMMA);
              put_rule();
              maybe_noise();
              if (chance(85)) begin
                put_byte(CH_COMMA);
                put_rule();
              end
            end
          end
        end
      end
      if (chance(4)) put_byte(8'($urandom_range(1, 255)));
    end
    put_byte(CH_NUL);
  endtask

  task automatic put_random(int n);
    int start;
    start = pushed;
    while (pushed - start < n) put_zone();
  endtask

  task automatic put_directed();
    put_zone_str("");
    put_zone_str("ES");
    put_zone_str("EST");
    put_zone_str(":EST5");
    put_zone_str("EST5");
    put_zone_str("EST+");
    put_zone_str("EST-23:59:59");
    put_zone_str("XYZ24");
    put_zone_str("XYZ1:60");
    put_zone_str("XYZ1234");
    put_zone_str("AAA5BBB");
    put_zone_str("AAA5BBB4");
    put_zone_str("EST5EDT4,M3.2.1/2,M11.1.1/2:00:00");
    put_zone_str("CET-1CEST,J60/2,300");
    put_zone_str("AAA5BBB,0,365");
    put_zone_str("AAA5BBB,J0,J365");
    put_zone_str("AAA5BBB,366,1");
    put_zone_str("AAA5BBB,M13.1.1,M1.1.1");
    put_zone_str("AAA5BBB,M1.6.1,M1.1.0");
    put_zone_str("AAA5BBB,M1,1.1,M2.2.2");
    put_zone_str("AAA5BBB,M1.1.1/24,J2");
    put_zone_str("AAA5BBB,M1.1.1/1:2:3,J2/0");
    put_zone_str("AAA5BBB,M1.1.1,M1.1.1,");
    put_zone_str("AAA5BBB,J1");
    put_zone_str("AAA5BBB,,J1");
    // high bytes act as name bytes
    put_byte(8'hC3);
    put_byte(8'hA9);
    put_byte(8'hFF);
    put_zone_str("5\x80\x7F\x01");
    // error followed by more bytes
    put_zone_str("AB5CDE,J1,J2");
  endtask

  // hold until every byte is accepted and every result has come back
  task automatic wait_drained();
    while (byte_backlog.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Driver: present the next byte at the falling edge
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_ch    <= byte_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_ch    <= 8'($urandom_range(0, 255));
      end
    end
  end

  // Receiver stall: long hold on request, random otherwise
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // Monitor: predict on accepted bytes, check accepted results
  // ------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    zone_verdict_t exp_v;
    if (!rst_n) begin
      in_took <= 1'b0;
      zp_reset();
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_zone_byte(in_ch);
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: valid_res=%0b length=%0d", out_valid_res, out_length);
          fail_cnt++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (out_valid_res !== exp_v.valid_res) begin
            $error("valid_res mismatch: expected %0b, actual %0b",
                   exp_v.valid_res, out_valid_res);
            fail_cnt++;
          end
          if (out_length !== exp_v.length) begin
            $error("length mismatch: expected %0d, actual %0d", exp_v.length, out_length);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_tz_string_validator failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sequence: reset, directed plus random, pressure, random under each idling mix
  // ------------------------------------------------------------------
  initial begin : sequencer
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    put_directed();
    put_random(PHASE_ITEMS);
    wait_drained();

    // stall the receiver long enough for the block to back up its input
    @(posedge clk);
    hold_req = 1'b1;
    repeat (20) begin
      put_zone_str("ABC");
      put_zone_str("XYZ9");
    end
    wait_drained();

    snd_idle_pct  = 48;
    rcv_stall_pct = 0;
    put_random(PHASE_ITEMS);
    wait_drained();

    snd_idle_pct  = 0;
    rcv_stall_pct = 48;
    put_random(PHASE_ITEMS);
    wait_drained();

    snd_idle_pct  = 33;
    rcv_stall_pct = 33;
    put_random(PHASE_ITEMS);
    wait_drained();

    repeat (END_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("tb_tz_string_validator passed");
    end else begin
      $display("tb_tz_string_validator failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/tzv_pkg.sv
sv/tzv_parser.sv
sv/tz_string_validator.sv
test/tb_tz_string_validator.sv
